// File: rtl/bdhl_pkg.sv
// Shared types and constants of the battery discharge history log.
package bdhl_pkg;

  // Operation codes carried by the kind field of a request.
  typedef enum logic [1:0] {
    KIND_RECORD   = 2'd0,
    KIND_READ     = 2'd1,
    KIND_ESTIMATE = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  // Sequencer states of the core.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_EST_A,
    ST_EST_B,
    ST_EST_MUL,
    ST_EST_PREP,
    ST_EST_DIV
  } state_e;

  // Capacity register value after reset, in mAh.
  localparam logic [15:0] CAP_RESET = 16'd1000;

  // One ring entry is minute stamp, charge and voltage.
  localparam int SAMPLE_W = 48;

  // Divider widths. Current: (drop * cap * 75 / 32) / minutes.
  // Runtime: (minutes * 12800) / (drop * 3).
  localparam int UA_NUM_W = 34;
  localparam int UA_DEN_W = 16;
  localparam int HR_NUM_W = 30;
  localparam int HR_DEN_W = 18;

  // Highest value of the running count modulo five.
  localparam logic [2:0] MOD5_LAST = 3'd4;

  // One result as it stands on the output ports.
  typedef struct packed {
    logic        accepted;
    logic        persist_due;
    logic        entry_valid;
    logic [15:0] entry_minute;
    logic [15:0] entry_charge_q8;
    logic [15:0] entry_millivolts;
    logic [5:0]  stored_entries;
    logic [15:0] total_recorded;
    logic        estimate_valid;
    logic [31:0] avg_current_ua;
    logic [31:0] runtime_tenths_hour;
  } result_t;

endpackage

// File: rtl/battery_discharge_history_log_core.sv
// Top level of the battery discharge history log: ring of samples and estimator.
//
//  Channel   Signals                                  Handshake
//  --------  ---------------------------------------  ---------------------------
//  request   kind_i minute_stamp_i charge_q8_i          taken when start && !busy
//            charge_ok_i millivolts_i position_i
//  result    accepted_o ... runtime_tenths_hour_o     done_o high for one cycle
//  config    cfg_wdata_i                              written when cfg_we_i
//
// Record, clear, a read past the held entries and an estimate on an empty log give
// their result from the execute state, a read of a held entry from the read-wait state.
// An estimate whose time did not advance or whose charge did not drop ends after
// reading its two entries; a valid estimate waits for the 34-step bit-serial divider
// for the average current, and the 30-step runtime divider runs beside it.
// Reset clears the count and sets the capacity to 1000 mAh; ring contents are
// only read where written. busy is high while a request is in work, and the
// result receiver cannot stall.
module battery_discharge_history_log_core #(
  parameter int LOG_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [1:0]  kind_i,
  input  logic [15:0] minute_stamp_i,
  input  logic [15:0] charge_q8_i,
  input  logic        charge_ok_i,
  input  logic [15:0] millivolts_i,
  input  logic [4:0]  position_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic        persist_due_o,
  output logic        entry_valid_o,
  output logic [15:0] entry_minute_o,
  output logic [15:0] entry_charge_q8_o,
  output logic [15:0] entry_millivolts_o,
  output logic [5:0]  stored_entries_o,
  output logic [15:0] total_recorded_o,
  output logic        estimate_valid_o,
  output logic [31:0] avg_current_ua_o,
  output logic [31:0] runtime_tenths_hour_o
);

  import bdhl_pkg::*;

  localparam int AW    = $clog2(LOG_DEPTH);
  localparam int CW    = AW + 1;
  localparam int CMP_W = (CW > 5) ? CW : 5;

  state_e       state_q, state_d;
  kind_e        kind_q;
  logic [15:0]  minute_q, chg_q, mv_q;
  logic         ok_q;
  logic [4:0]   pos_q;
  logic [15:0]  cap_q;
  logic [15:0]  count_q, count_d;
  logic [2:0]   mod5_q, mod5_d;
  logic [AW-1:0] addr_b_q;
  logic [15:0]  a_min_q, a_chg_q;
  logic [15:0]  minutes_q, drop_q;
  logic         est_ok_q;
  logic [31:0]  prod_q;
  result_t      res_q, res_d;
  logic         done_q;
  logic         emit;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [15:0]   rd_min, rd_chg, rd_mv;

  logic          sample_ok;
  logic          over_cur, over_nx;
  logic [CW-1:0] held_cur, held_nx;
  logic [AW-1:0] oldest;
  logic [CMP_W-1:0] rd_sum;
  logic [AW-1:0] rd_addr;
  logic          rd_hit;
  logic [CW-1:0] b_sum;

  logic          div_start;
  logic [38:0]   ua_scaled;
  logic [UA_NUM_W-1:0] ua_num, ua_quot;
  logic [HR_NUM_W-1:0] hr_num, hr_quot;
  logic [HR_DEN_W-1:0] hr_den;
  logic          ua_busy, hr_busy;
  logic [31:0]   ua_sat;

  // Occupancy and ring positions derived from the count.
  assign sample_ok = ok_q && (mv_q != 16'd0);
  assign over_cur  = (count_q > 16'(LOG_DEPTH));
  assign held_cur  = over_cur ? CW'(LOG_DEPTH) : count_q[CW-1:0];
  assign oldest    = over_cur ? count_q[AW-1:0] : '0;
  assign rd_sum    = CMP_W'(oldest) + CMP_W'(pos_q);
  assign rd_addr   = rd_sum[AW-1:0];
  assign rd_hit    = (CMP_W'(pos_q) < CMP_W'(held_cur));
  assign b_sum     = CW'(oldest) + held_cur - CW'(1);

  assign over_nx = (count_d > 16'(LOG_DEPTH));
  assign held_nx = over_nx ? CW'(LOG_DEPTH) : count_d[CW-1:0];

  assign rd_min = ram_rdata[47:32];
  assign rd_chg = ram_rdata[31:16];
  assign rd_mv  = ram_rdata[15:0];

  // Next count and count modulo five; a wrap to zero restarts the residue.
  always_comb begin
    count_d = count_q;
    mod5_d  = mod5_q;
    if (state_q == ST_EXEC) begin
      if (kind_q == KIND_RECORD && sample_ok) begin
        count_d = count_q + 16'd1;
        mod5_d  = (count_q == 16'hFFFF || mod5_q == MOD5_LAST) ? 3'd0 : mod5_q + 3'd1;
      end else if (kind_q == KIND_CLEAR) begin
        count_d = '0;
        mod5_d  = '0;
      end
    end
  end

  // Estimator operands: constant factors as shift-and-add.
  assign ua_scaled = {prod_q, 6'd0} + {4'd0, prod_q, 3'd0} + {6'd0, prod_q, 1'b0}
                   + {7'd0, prod_q};
  assign ua_num    = ua_scaled[38:5];
  assign hr_num    = {1'b0, minutes_q, 13'd0} + {2'd0, minutes_q, 12'd0}
                   + {5'd0, minutes_q, 9'd0};
  assign hr_den    = {1'b0, drop_q, 1'b0} + {2'd0, drop_q};
  assign ua_sat    = (ua_quot[UA_NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : ua_quot[31:0];

  // Sequencer: next state, memory control and result assembly.
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = oldest;
    div_start = 1'b0;
    emit      = 1'b0;
    res_d     = '0;
    res_d.stored_entries = 6'(held_nx);
    res_d.total_recorded = count_d;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (kind_q)
          KIND_RECORD: begin
            if (sample_ok) begin
              ram_we            = 1'b1;
              res_d.accepted    = 1'b1;
              res_d.persist_due = (mod5_d == 3'd0);
            end
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
          KIND_READ: begin
            if (rd_hit) begin
              ram_re    = 1'b1;
              ram_raddr = rd_addr;
              state_d   = ST_READ_WAIT;
            end else begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end
          KIND_ESTIMATE: begin
            if (count_q != 16'd0) begin
              ram_re  = 1'b1;
              state_d = ST_EST_A;
            end else begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end
          KIND_CLEAR: begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_READ_WAIT: begin
        res_d.entry_valid      = 1'b1;
        res_d.entry_minute     = rd_min;
        res_d.entry_charge_q8  = rd_chg;
        res_d.entry_millivolts = rd_mv;
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
      ST_EST_A: begin
        ram_re    = 1'b1;
        ram_raddr = addr_b_q;
        state_d   = ST_EST_B;
      end
      ST_EST_B: begin
        state_d = ST_EST_MUL;
      end
      ST_EST_MUL: begin
        if (est_ok_q) begin
          state_d = ST_EST_PREP;
        end else begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EST_PREP: begin
        div_start = 1'b1;
        state_d   = ST_EST_DIV;
      end
      ST_EST_DIV: begin
        if (!ua_busy && !hr_busy) begin
          res_d.estimate_valid      = 1'b1;
          res_d.avg_current_ua      = ua_sat;
          res_d.runtime_tenths_hour = 32'(hr_quot);
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      mod5_q  <= '0;
      cap_q   <= CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mod5_q  <= mod5_d;
      done_q  <= emit;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q   <= kind_e'(kind_i);
      minute_q <= minute_stamp_i;
      chg_q    <= charge_q8_i;
      ok_q     <= charge_ok_i;
      mv_q     <= millivolts_i;
      pos_q    <= position_i;
    end
  end

  // Estimator datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      addr_b_q <= b_sum[AW-1:0];
    end
    if (state_q == ST_EST_A) begin
      a_min_q <= rd_min;
      a_chg_q <= rd_chg;
    end
    if (state_q == ST_EST_B) begin
      minutes_q <= rd_min - a_min_q;
      drop_q    <= a_chg_q - rd_chg;
      est_ok_q  <= (rd_min > a_min_q) && (a_chg_q > rd_chg);
    end
    if (state_q == ST_EST_MUL) begin
      prod_q <= drop_q * cap_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  bdhl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (LOG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({minute_q, chg_q, mv_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bdhl_div #(
    .NUM_W (UA_NUM_W),
    .DEN_W (UA_DEN_W)
  ) u_div_ua (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ua_num),
    .den_i   (minutes_q),
    .busy_o  (ua_busy),
    .quot_o  (ua_quot)
  );

  bdhl_div #(
    .NUM_W (HR_NUM_W),
    .DEN_W (HR_DEN_W)
  ) u_div_hr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (hr_num),
    .den_i   (hr_den),
    .busy_o  (hr_busy),
    .quot_o  (hr_quot)
  );

  // Port drive.
  assign busy                  = (state_q != ST_IDLE);
  assign done_o                = done_q;
  assign accepted_o            = res_q.accepted;
  assign persist_due_o         = res_q.persist_due;
  assign entry_valid_o         = res_q.entry_valid;
  assign entry_minute_o        = res_q.entry_minute;
  assign entry_charge_q8_o     = res_q.entry_charge_q8;
  assign entry_millivolts_o    = res_q.entry_millivolts;
  assign stored_entries_o      = res_q.stored_entries;
  assign total_recorded_o      = res_q.total_recorded;
  assign estimate_valid_o      = res_q.estimate_valid;
  assign avg_current_ua_o      = res_q.avg_current_ua;
  assign runtime_tenths_hour_o = res_q.runtime_tenths_hour;

endmodule

// File: rtl/bdhl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdhl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/bdhl_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module bdhl_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh   = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    fits     = (rem_sh >= {1'b0, den_q});
    rem_diff = rem_sh - {1'b0, den_q};
  end

  // Step counter and run flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CNT_W'(NUM_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_q <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers; the numerator shifts out as
  // quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= fits ? rem_diff : rem_sh;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = run_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/bdhl_chk.sv
// Port-level checker for the battery discharge history log and its bind.
module bdhl_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        accepted_o,
  input logic        entry_valid_o,
  input logic        estimate_valid_o,
  input logic [5:0]  stored_entries_o,
  input logic [15:0] total_recorded_o
);

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // A result appears only once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Results of separate requests never come in adjacent cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // At most one operation-specific flag is set in a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $countones({accepted_o, entry_valid_o, estimate_valid_o}) <= 1)
    else $error("result flags of different operations together");

  // An empty count holds no entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && total_recorded_o == 16'd0 |-> stored_entries_o == 6'd0)
    else $error("entries held with zero count");

endmodule

bind battery_discharge_history_log_core bdhl_chk u_bdhl_chk (.*);

// File: sim/tb.sv
// Self-checking testbench for the battery discharge history log core.
module tb;
  import bdhl_pkg::*;

  localparam int DEPTH = 32;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 145;

  // One request as it stands on the input ports.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] minute;
    logic [15:0] charge;
    logic        charge_ok;
    logic [15:0] millivolts;
    logic [4:0]  position;
  } log_req_t;

  // Keeps its own copy of the sample ring, the count and the capacity, works out
  // the result of every accepted request and checks results in order.
  class discharge_log_scoreboard;
    logic [15:0] ring_minute [DEPTH];
    logic [15:0] ring_charge [DEPTH];
    logic [15:0] ring_mv [DEPTH];
    logic [15:0] count;
    logic [15:0] capacity;
    result_t     expected_results [$];
    int          errors;

    function new();
      count = '0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [15:0] value);
      capacity = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int unsigned held();
      return (count > DEPTH) ? DEPTH : count;
    endfunction

    function int unsigned oldest();
      return (count > DEPTH) ? (count % DEPTH) : 0;
    endfunction

    // Works out the result of one accepted request and updates the log copy.
    function void note_request(log_req_t r);
      result_t         res;
      int unsigned     slot;
      int unsigned     first;
      int unsigned     last;
      longint unsigned span;
      longint unsigned drop;
      longint unsigned current;
      longint unsigned runtime;
      res = '0;
      case (r.kind)
        KIND_RECORD: begin
          if (r.charge_ok && r.millivolts != 16'd0) begin
            slot = count % DEPTH;
            ring_minute[slot] = r.minute;
            ring_charge[slot] = r.charge;
            ring_mv[slot] = r.millivolts;
            count = count + 16'd1;
            res.accepted = 1'b1;
            res.persist_due = (count % 5 == 0);
          end
        end
        KIND_READ: begin
          if (r.position < held()) begin
            slot = (oldest() + r.position) % DEPTH;
            res.entry_valid = 1'b1;
            res.entry_minute = ring_minute[slot];
            res.entry_charge_q8 = ring_charge[slot];
            res.entry_millivolts = ring_mv[slot];
          end
        end
        KIND_ESTIMATE: begin
          if (held() > 0) begin
            first = oldest();
            last = (first + held() - 1) % DEPTH;
            if (ring_minute[last] > ring_minute[first] &&
                ring_charge[first] > ring_charge[last]) begin
              span = 64'(ring_minute[last]) - 64'(ring_minute[first]);
              drop = 64'(ring_charge[first]) - 64'(ring_charge[last]);
              current = (drop * capacity * 64'd60000) / (64'd25600 * span);
              runtime = (64'd25600 * span * 64'd10) / (drop * 64'd60);
              if (current > 64'hFFFF_FFFF) begin
                current = 64'hFFFF_FFFF;
              end
              res.estimate_valid = 1'b1;
              res.avg_current_ua = current[31:0];
              res.runtime_tenths_hour = runtime[31:0];
            end
          end
        end
        default: begin
          count = '0;
        end
      endcase
      res.stored_entries = 6'(held());
      res.total_recorded = count;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, seen);
      end
    endfunction

    // Compares one result with the oldest expectation, field by field.
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $error("result arrived with no request outstanding");
        return;
      end
      want = expected_results.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("persist_due", want.persist_due, got.persist_due);
      compare_field("entry_valid", want.entry_valid, got.entry_valid);
      compare_field("entry_minute", want.entry_minute, got.entry_minute);
      compare_field("entry_charge_q8", want.entry_charge_q8, got.entry_charge_q8);
      compare_field("entry_millivolts", want.entry_millivolts, got.entry_millivolts);
      compare_field("stored_entries", want.stored_entries, got.stored_entries);
      compare_field("total_recorded", want.total_recorded, got.total_recorded);
      compare_field("estimate_valid", want.estimate_valid, got.estimate_valid);
      compare_field("avg_current_ua", want.avg_current_ua, got.avg_current_ua);
      compare_field("runtime_tenths_hour", want.runtime_tenths_hour,
                    got.runtime_tenths_hour);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  log_req_t    req = '0;

  logic        busy;
  logic        done_o;
  logic        accepted_o;
  logic        persist_due_o;
  logic        entry_valid_o;
  logic [15:0] entry_minute_o;
  logic [15:0] entry_charge_q8_o;
  logic [15:0] entry_millivolts_o;
  logic [5:0]  stored_entries_o;
  logic [15:0] total_recorded_o;
  logic        estimate_valid_o;
  logic [31:0] avg_current_ua_o;
  logic [31:0] runtime_tenths_hour_o;
  result_t     seen;

  discharge_log_scoreboard sb = new();
  int          quiet_cycles = 0;
  logic [15:0] trend_minute;
  logic [15:0] trend_charge;

  battery_discharge_history_log_core #(
    .LOG_DEPTH(DEPTH)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .kind_i               (req.kind),
    .minute_stamp_i       (req.minute),
    .charge_q8_i          (req.charge),
    .charge_ok_i          (req.charge_ok),
    .millivolts_i         (req.millivolts),
    .position_i           (req.position),
    .done_o               (done_o),
    .accepted_o           (accepted_o),
    .persist_due_o        (persist_due_o),
    .entry_valid_o        (entry_valid_o),
    .entry_minute_o       (entry_minute_o),
    .entry_charge_q8_o    (entry_charge_q8_o),
    .entry_millivolts_o   (entry_millivolts_o),
    .stored_entries_o     (stored_entries_o),
    .total_recorded_o     (total_recorded_o),
    .estimate_valid_o     (estimate_valid_o),
    .avg_current_ua_o     (avg_current_ua_o),
    .runtime_tenths_hour_o(runtime_tenths_hour_o)
  );

  assign seen = {accepted_o, persist_due_o, entry_valid_o, entry_minute_o,
                 entry_charge_q8_o, entry_millivolts_o, stored_entries_o,
                 total_recorded_o, estimate_valid_o, avg_current_ua_o,
                 runtime_tenths_hour_o};

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Note accepted requests, check results, and stop a run that has gone quiet.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      sb.note_request(req);
    end
    if (rst_ni && done_o) begin
      sb.check_result(seen);
    end
    if ((rst_ni && start && !busy) || (rst_ni && done_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(65535));
  endfunction

  function automatic log_req_t make_req(kind_e kind, logic [15:0] minute,
                                        logic [15:0] charge, logic ok,
                                        logic [15:0] mv, logic [4:0] pos);
    log_req_t r;
    r.kind = kind;
    r.minute = minute;
    r.charge = charge;
    r.charge_ok = ok;
    r.millivolts = mv;
    r.position = pos;
    return r;
  endfunction

  // Presents one request and returns at the edge that takes it.
  task automatic send(input log_req_t r, input bit gaps);
    if (gaps && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // Lets every outstanding result arrive and the core settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(value);
  endtask

  // Next sample of a discharge curve: time moves on, charge mostly falls.
  task automatic next_sample(output log_req_t r);
    int roll;
    roll = $urandom_range(99);
    r = make_req(KIND_RECORD, rand16(), rand16(), 1'b1,
                 16'($urandom_range(1, 65535)), 5'($urandom_range(31)));
    if (roll < 4) begin
      r.charge_ok = 1'b0;
    end else if (roll < 8) begin
      r.millivolts = '0;
    end else begin
      if ($urandom_range(99) < 5) begin
        trend_minute = rand16();
      end else begin
        trend_minute = trend_minute + 16'($urandom_range(0, 20));
      end
      if ($urandom_range(99) < 5) begin
        trend_charge = trend_charge + 16'($urandom_range(0, 2000));
      end else begin
        trend_charge = trend_charge - 16'($urandom_range(0, 300));
      end
      r.minute = trend_minute;
      r.charge = trend_charge;
      if ($urandom_range(1) == 0) begin
        r.millivolts = 16'($urandom_range(3000, 4200));
      end
    end
  endtask

  // Mostly discharge curves with reads and estimates, some clears and noise.
  task automatic random_phase(input int items, input bit gaps);
    log_req_t r;
    int       roll;
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        next_sample(r);
      end else if (roll < 78) begin
        r = make_req(KIND_READ, rand16(), rand16(), 1'($urandom_range(1)), rand16(),
                     5'($urandom_range(31)));
      end else if (roll < 93) begin
        r = make_req(KIND_ESTIMATE, rand16(), rand16(), 1'($urandom_range(1)),
                     rand16(), 5'($urandom_range(31)));
      end else if (roll < 95) begin
        r = make_req(KIND_CLEAR, rand16(), rand16(), 1'($urandom_range(1)), rand16(),
                     5'($urandom_range(31)));
        trend_minute = rand16();
        trend_charge = rand16();
      end else begin
        r = make_req(KIND_RECORD, rand16(), rand16(), 1'($urandom_range(1)), rand16(),
                     5'($urandom_range(31)));
      end
      send(r, gaps);
    end
  endtask

  // Main sequence.
  initial begin
    log_req_t r;
    trend_minute = rand16();
    trend_charge = rand16();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty log, invalid samples, flat time, rising charge, extremes, persist flag.
    send(make_req(KIND_ESTIMATE, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_READ, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'd50, 16'd30000, 1'b0, 16'd3700, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'd50, 16'd30000, 1'b1, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'd100, 16'd60000, 1'b1, 16'd3700, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'd100, 16'd50000, 1'b1, 16'd3650, 5'd0), 1'b1);
    send(make_req(KIND_ESTIMATE, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'd200, 16'd61000, 1'b1, 16'd3900, 5'd0), 1'b1);
    send(make_req(KIND_ESTIMATE, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'hFFFF, 16'd0, 1'b1, 16'hFFFF, 5'd0), 1'b1);
    send(make_req(KIND_ESTIMATE, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'd0, 16'hFFFF, 1'b1, 16'd1, 5'd0), 1'b1);
    send(make_req(KIND_READ, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_READ, 16'd0, 16'd0, 1'b0, 16'd0, 5'd4), 1'b1);
    send(make_req(KIND_READ, 16'd0, 16'd0, 1'b0, 16'd0, 5'd5), 1'b1);
    send(make_req(KIND_READ, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 5'd31), 1'b1);
    send(make_req(KIND_ESTIMATE, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_CLEAR, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_READ, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);

    // Largest capacity with a full drop in one minute saturates the current.
    write_capacity(16'hFFFF);
    send(make_req(KIND_RECORD, 16'd0, 16'hFFFF, 1'b1, 16'd4200, 5'd0), 1'b1);
    send(make_req(KIND_RECORD, 16'd1, 16'd0, 1'b1, 16'd3000, 5'd0), 1'b1);
    send(make_req(KIND_ESTIMATE, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    send(make_req(KIND_CLEAR, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);

    // Random phases over several capacities; the second one runs without gaps.
    write_capacity(16'd1);
    random_phase(PHASE_ITEMS, 1'b1);
    write_capacity(16'hFFFF);
    random_phase(PHASE_ITEMS, 1'b0);
    write_capacity(16'($urandom_range(1, 65535)));
    random_phase(PHASE_ITEMS, 1'b1);
    write_capacity(16'($urandom_range(1, 65535)));
    random_phase(PHASE_ITEMS, 1'b1);

    // Clear, then grow the log from empty with reads and estimates after each sample.
    send(make_req(KIND_CLEAR, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    for (int i = 0; i < 12; i++) begin
      next_sample(r);
      r.charge_ok = 1'b1;
      r.millivolts = 16'($urandom_range(1, 65535));
      send(r, 1'b1);
      send(make_req(KIND_READ, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
      send(make_req(KIND_READ, 16'd0, 16'd0, 1'b0, 16'd0, 5'($urandom_range(31))),
           1'b1);
      send(make_req(KIND_ESTIMATE, 16'd0, 16'd0, 1'b0, 16'd0, 5'd0), 1'b1);
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: battery_discharge_history_log_core.f
rtl/bdhl_pkg.sv
rtl/bdhl_ram.sv
rtl/bdhl_div.sv
rtl/battery_discharge_history_log_core.sv
rtl/bdhl_chk.sv
sim/tb.sv
